// ===== rtl/core/wwsm_pkg.sv =====
package wwsm_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int COLUMN_MAX  = 65535;
   localparam int LINE_MAX    = 16777215;
   localparam int WINDOW_LEN  = PATTERN_MAX + 1;
   localparam int COUNT_MAX   = COLUMN_MAX + PATTERN_MAX;
   localparam int COUNT_W     = $clog2(COUNT_MAX + 1);

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;

   localparam logic [2:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [2:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [2:0] CSR_PATTERN_LENGTH = 3'd2;
   localparam logic [2:0] CSR_MATCH_MODE     = 3'd3;
   localparam logic [2:0] CSR_EXACT_CASE     = 3'd4;

   localparam logic [7:0] UNDERSCORE = 8'h5f;

   typedef struct packed {
      logic [127:0] pattern;
      logic [4:0]   length;
      logic [1:0]   mode;
      logic         exact_case;
   } cfg_type;

   typedef struct packed {
      logic        hit;
      logic        left_ok;
      logic [15:0] column;
   } match_type;

   function automatic logic word_char(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) || (c == UNDERSCORE);
   endfunction

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
      if (!exact && (c inside {[8'h41:8'h5a]})) begin
         return c + 8'd32;
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/whole_word_substring_matcher_top.sv =====
// A byte is held in the input register and its result then in the result register.
// Throughput: one request per cycle unless the result is stalled; the window compare is a
// single pass of parallel byte comparators between the input and result registers.
// Reset: synchronous, active high; clears the byte count, pending match, history and
// configuration (exact case compare resets on) and sets the line number to 1.
module whole_word_substring_matcher_top
   import wwsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [23:0] line_number, [39:24] column
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   cfg_type            cfg_ff;
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_eol_ff;
   logic [7:0]         hist_ff [PATTERN_MAX];
   logic [COUNT_W-1:0] count_ff;
   logic [23:0]        line_ff;
   logic               pend_ff;
   logic [15:0]        pend_col_ff;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_line_ff;
   logic [15:0]        rsp_col_ff;

   logic [7:0]         window_in [WINDOW_LEN];
   logic [COUNT_W-1:0] count_in;
   logic               advance;
   logic               step;
   logic               csr_write;
   logic               rsp_valid_in;
   logic [15:0]        rsp_col_in;
   logic               pend_in;
   match_type          match;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign step       = s1_valid_ff && advance;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   always_comb begin
      window_in[0] = s1_byte_ff;
      for (int j = 1; j < WINDOW_LEN; j++) begin
         window_in[j] = hist_ff[j-1];
      end
   end

   assign count_in = (count_ff < COUNT_W'(COUNT_MAX)) ? count_ff + COUNT_W'(1) : count_ff;

   wwsm_window_match u_match (
      .window (window_in),
      .count  (count_in),
      .cfg    (cfg_ff),
      .match  (match)
   );

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_col_in   = pend_col_ff;
      pend_in      = 1'b0;
      if (s1_eol_ff) begin
         rsp_valid_in = pend_ff;
      end else begin
         rsp_valid_in = pend_ff && !word_char(s1_byte_ff);
         if (match.hit && cfg_ff.mode == MODE_PLAIN) begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = match.column;
         end
         pend_in = match.hit && (cfg_ff.mode == MODE_IDENT) && match.left_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_eol_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pattern: '0, length: '0, mode: MODE_PLAIN, exact_case: 1'b1};
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_LOW:    cfg_ff.pattern[63:0]   <= csr_data;
            CSR_PATTERN_HIGH:   cfg_ff.pattern[127:64] <= csr_data;
            CSR_PATTERN_LENGTH: cfg_ff.length          <= csr_data[4:0];
            CSR_MATCH_MODE:     cfg_ff.mode            <= csr_data[1:0];
            CSR_EXACT_CASE:     cfg_ff.exact_case      <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         line_ff     <= 24'd1;
         pend_ff     <= 1'b0;
         pend_col_ff <= '0;
         for (int j = 0; j < PATTERN_MAX; j++) begin
            hist_ff[j] <= 8'd0;
         end
      end else begin
         if (step) begin
            if (s1_eol_ff) begin
               count_ff <= '0;
               if (line_ff < 24'(LINE_MAX)) begin
                  line_ff <= line_ff + 24'd1;
               end
            end else begin
               count_ff <= count_in;
               for (int j = 0; j < PATTERN_MAX; j++) begin
                  hist_ff[j] <= window_in[j];
               end
            end
            pend_ff <= pend_in;
            if (pend_in) begin
               pend_col_ff <= match.column;
            end
         end
         // a write to a defined register (index 0 to 4) drops any pending match
         if (csr_write && csr_index <= CSR_EXACT_CASE) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && rsp_valid_in;
      end
      if (step) begin
         rsp_line_ff <= line_ff;
         rsp_col_ff  <= rsp_col_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_line_ff};

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 24'd0)
      else $error("line counter reached zero");

   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_col_ff != 16'd0)
      else $error("result with zero column");

   a_pend_mode: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> cfg_ff.mode == MODE_IDENT)
      else $error("pending match outside identifier mode");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(COUNT_MAX))
      else $error("byte count beyond saturation");

endmodule

// ===== rtl/core/wwsm_window_match.sv =====
module wwsm_window_match
   import wwsm_pkg::*;
(
   input  logic [7:0]         window [WINDOW_LEN],
   input  logic [COUNT_W-1:0] count,
   input  cfg_type            cfg,
   output match_type          match
);

   logic [7:0]         pat_bytes [PATTERN_MAX];
   logic [7:0]         aligned   [PATTERN_MAX];
   logic [4:0]         src_idx   [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] lane_ok;
   logic               len_ok;
   logic [4:0]         edge_idx;
   logic [COUNT_W-1:0] col_wide;

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pat_bytes[k] = cfg.pattern[k*8 +: 8];
      end
      // pattern reversed so that window position j lines up with byte len-1-j
      for (int j = 0; j < PATTERN_MAX; j++) begin
         src_idx[j] = cfg.length - 5'(j) - 5'd1;
         aligned[j] = pat_bytes[src_idx[j][3:0]];
         lane_ok[j] = (5'(j) >= cfg.length) ||
                      (fold_byte(window[j], cfg.exact_case) ==
                       fold_byte(aligned[j], cfg.exact_case));
      end
   end

   assign len_ok = (cfg.length != 5'd0) && (cfg.length <= 5'(PATTERN_MAX)) &&
                   (cfg.mode <= MODE_IDENT) && (count >= COUNT_W'(cfg.length));

   assign edge_idx = (cfg.length <= 5'(PATTERN_MAX)) ? cfg.length : 5'd0;

   assign col_wide = count - COUNT_W'(cfg.length) + COUNT_W'(1);

   assign match.hit     = len_ok && (&lane_ok);
   assign match.left_ok = !((count > COUNT_W'(cfg.length)) && word_char(window[edge_idx]));
   assign match.column  = (col_wide > COUNT_W'(COLUMN_MAX)) ? 16'(COLUMN_MAX) : col_wide[15:0];

endmodule
